[hw/rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros shared by the RTL of the poll master
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every clock edge outside reset
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check on every clock edge, reset included
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hw/rtl/rrpm_pkg.sv]
// ----------------------------------------------------------------------------
// rrpm_pkg
// Types and codes shared by the round robin poll master.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rrpm_pkg;

  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_RESP  = 2'd1;
  localparam logic [1:0] OP_DATA  = 2'd2;
  localparam logic [1:0] OP_ALARM = 2'd3;

  localparam logic [2:0] FK_POLL  = 3'd0;
  localparam logic [2:0] FK_GET   = 3'd1;
  localparam logic [2:0] FK_ACK   = 3'd2;
  localparam logic [2:0] FK_ERR   = 3'd3;
  localparam logic [2:0] FK_STATE = 3'd4;

  localparam logic [1:0] VD_OK        = 2'd0;
  localparam logic [1:0] VD_WRONG_PIN = 2'd2;

  localparam logic [1:0] REG_POLL_INTERVAL = 2'd0;
  localparam logic [1:0] REG_RSP_TIMEOUT   = 2'd1;
  localparam logic [1:0] REG_OFFLINE_THR   = 2'd2;

  localparam logic [15:0] POLL_INTERVAL_RST = 16'd100;
  localparam logic [15:0] RSP_TIMEOUT_RST   = 16'd100;
  localparam logic [3:0]  OFFLINE_THR_RST   = 4'd3;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = 2;
  localparam int FIFO_CNT_W = 3;

  typedef enum logic [3:0] {
    PH_IDLE      = 4'b0001,
    PH_WAIT_POLL = 4'b0010,
    PH_WAIT_DATA = 4'b0100,
    PH_DONE      = 4'b1000
  } phase_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [2:0] target;
    logic       err;
    logic [2:0] state;
    logic [3:0] mask;
    logic       last;
  } frame_t;

  typedef struct packed {
    logic   v0;
    logic   v1;
    frame_t f0;
    frame_t f1;
  } push_t;

endpackage

`default_nettype wire

[hw/rtl/rrpm_frame_fifo.sv]
// ----------------------------------------------------------------------------
// rrpm_frame_fifo
// Four-entry frame queue: takes up to two frames per cycle, sends one per cycle while out_ready is high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module rrpm_frame_fifo
  import rrpm_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire push_t  push,
  output logic        room,
  output logic        out_valid,
  output frame_t      out_frame,
  input  wire logic   out_ready
);

  frame_t                mem [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wp_r, wp_nxt;
  logic [FIFO_PTR_W-1:0] rp_r, rp_nxt;
  logic [FIFO_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                  pop;
  logic [FIFO_CNT_W-1:0] n_push;

  assign pop       = out_valid && out_ready;
  assign out_valid = (cnt_r != '0);
  assign out_frame = mem[rp_r];
  assign room      = (cnt_r <= FIFO_CNT_W'(FIFO_DEPTH - 2));
  assign n_push    = FIFO_CNT_W'(push.v0) + FIFO_CNT_W'(push.v1);

  always_comb begin
    wp_nxt  = wp_r + FIFO_PTR_W'(n_push);
    rp_nxt  = rp_r + FIFO_PTR_W'(pop);
    cnt_nxt = cnt_r + n_push - FIFO_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.v0) begin
      mem[wp_r] <= push.f0;
    end
    if (push.v1) begin
      mem[wp_r + FIFO_PTR_W'(1)] <= push.f1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  `ASSERT_CLK(a_cnt_bound, cnt_r <= FIFO_CNT_W'(FIFO_DEPTH), "frame queue count out of range")
  `ASSERT_CLK(a_push_room, push.v0 |-> room, "frame pushed without room")
  `ASSERT_CLK(a_pop_drain, (pop && !push.v0) |=> cnt_r == $past(cnt_r) - FIFO_CNT_W'(1), "pop lost")

endmodule

`default_nettype wire

[hw/rtl/rs485_round_robin_poll_master.sv]
// ----------------------------------------------------------------------------
// rs485_round_robin_poll_master
// Round robin bus poll master driven by parsed bus events.
// ----------------------------------------------------------------------------
// Input stream carries one event per request: tick, status response, data
// payload or alarm state change (kind in in_tuser). The event is handled in
// the cycle it is accepted; its zero, one or two frames are registered in a
// four-entry queue and appear on the output stream in order, one frame per
// cycle while out_tready is high, the final frame of an event marked by
// out_tlast. Throughput: one event per cycle while the output side drains;
// an event that makes two frames sends them one after the other through
// the single queue read port.
// in_tready drops while fewer than two queue entries are free, so a stalled
// receiver backs up into the input once three or four frames are waiting.
// Reset clears phase, counters, slave marks and the queue; the registers
// return to poll interval 100, response timeout 100, offline threshold 3.
// Registers on the APB port: 0x0 poll interval, 0x4 response timeout,
// 0x8 offline threshold. Write them only while the block is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module rs485_round_robin_poll_master
  import rrpm_pkg::*;
#(
  parameter int NUM_SLAVES = 4
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // slave_id[3:0], pending_flag[4], verdict[6:5], new_alarm_state[9:7]
  input  wire logic [15:0] in_tdata,
  // opcode[1:0]
  input  wire logic [1:0]  in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // target_slave[2:0], error_code[3], state_code[6:4], online_mask[10:7]
  output logic [15:0]      out_tdata,
  // frame_kind[2:0]
  output logic [2:0]       out_tuser,
  output logic             out_tlast,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [3:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  localparam int IDX_W  = (NUM_SLAVES > 1) ? $clog2(NUM_SLAVES) : 1;
  localparam int MASK_N = (NUM_SLAVES < 4) ? NUM_SLAVES : 4;

  logic [15:0] poll_intv_r, rsp_tmo_r;
  logic [3:0]  off_thr_r;

  phase_t          phase_r, phase_nxt;
  logic [IDX_W-1:0] cur_r, cur_nxt;
  logic [15:0]     sadv_r, sadv_nxt;
  logic [15:0]     sact_r, sact_nxt;
  logic            online_r [NUM_SLAVES];
  logic            online_nxt [NUM_SLAVES];
  logic [3:0]      tc_r [NUM_SLAVES];
  logic [3:0]      tc_nxt [NUM_SLAVES];
  logic            bcast_r, bcast_nxt;
  logic [2:0]      known_r, known_nxt;

  logic        in_acc;
  logic        cfg_wr;
  logic [1:0]  opc;
  logic [3:0]  sid;
  logic        pend;
  logic [1:0]  verdict;
  logic [2:0]  nstate;
  logic        sid_ok;
  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] sel;
  logic [IDX_W-1:0] cur_adv;
  logic [2:0]  cur_id;
  logic        room;
  push_t       push;
  frame_t      out_frame;

  assign in_acc    = in_tvalid && in_tready;
  assign in_tready = room;
  assign opc       = in_tuser;
  assign sid       = in_tdata[3:0];
  assign pend      = in_tdata[4];
  assign verdict   = in_tdata[6:5];
  assign nstate    = in_tdata[9:7];
  assign sid_ok    = (sid != 4'd0) && (sid <= 4'(NUM_SLAVES));
  assign idx       = IDX_W'(sid - 4'd1);
  assign sel       = (opc == OP_TICK) ? cur_r : idx;
  assign cur_adv   = (cur_r == IDX_W'(NUM_SLAVES - 1)) ? '0 : cur_r + IDX_W'(1);
  assign cur_id    = 3'(cur_r) + 3'd1;

  always_comb begin
    logic        pre_v, main_v;
    frame_t      pre_f, main_f;
    logic [3:0]  tc_inc;
    logic [3:0]  mask;
    logic        advance;

    phase_nxt  = phase_r;
    cur_nxt    = cur_r;
    sadv_nxt   = sadv_r;
    sact_nxt   = sact_r;
    online_nxt = online_r;
    tc_nxt     = tc_r;
    bcast_nxt  = bcast_r;
    known_nxt  = known_r;
    pre_v      = 1'b0;
    main_v     = 1'b0;
    pre_f      = '0;
    main_f     = '0;
    advance    = 1'b0;
    mask       = '0;
    tc_inc     = (tc_r[sel] == 4'hF) ? tc_r[sel] : tc_r[sel] + 4'd1;

    if (in_acc) begin
      case (opc)
        OP_TICK: begin
          sadv_nxt = (sadv_r == 16'hFFFF) ? sadv_r : sadv_r + 16'd1;
          sact_nxt = (sact_r == 16'hFFFF) ? sact_r : sact_r + 16'd1;
          if (bcast_r && phase_r == PH_IDLE) begin
            pre_v       = 1'b1;
            pre_f.kind  = FK_STATE;
            pre_f.state = known_r;
            bcast_nxt   = 1'b0;
            sadv_nxt    = '0;
          end
          case (phase_r)
            PH_IDLE: begin
              if (sadv_nxt >= poll_intv_r) begin
                main_v        = 1'b1;
                main_f.kind   = FK_POLL;
                main_f.target = cur_id;
                phase_nxt     = PH_WAIT_POLL;
                sact_nxt      = '0;
              end
            end
            PH_WAIT_POLL, PH_WAIT_DATA: begin
              if (sact_nxt >= rsp_tmo_r) begin
                tc_nxt[sel] = tc_inc;
                if (online_r[sel] && tc_inc >= off_thr_r) begin
                  online_nxt[sel] = 1'b0;
                end
                advance = 1'b1;
              end
            end
            default: begin
              advance = 1'b1;
            end
          endcase
        end
        OP_RESP, OP_DATA: begin
          if (sid_ok && (opc == OP_DATA || idx == cur_r)) begin
            if (!online_r[sel]) begin
              pre_v        = 1'b1;
              pre_f.kind   = FK_STATE;
              pre_f.target = sid[2:0];
              pre_f.state  = known_r;
            end
            online_nxt[sel] = 1'b1;
            tc_nxt[sel]     = '0;
            main_f.target   = sid[2:0];
            if (opc == OP_RESP) begin
              if (pend) begin
                main_v      = 1'b1;
                main_f.kind = FK_GET;
                phase_nxt   = PH_WAIT_DATA;
                sact_nxt    = '0;
              end else begin
                advance = 1'b1;
              end
            end else begin
              main_v      = 1'b1;
              main_f.kind = (verdict == VD_OK) ? FK_ACK : FK_ERR;
              main_f.err  = (verdict == VD_WRONG_PIN);
              advance     = 1'b1;
            end
          end
        end
        default: begin
          if (nstate != known_r) begin
            known_nxt = nstate;
            bcast_nxt = 1'b1;
          end
        end
      endcase
    end

    if (advance) begin
      cur_nxt   = cur_adv;
      phase_nxt = PH_IDLE;
      sadv_nxt  = '0;
    end

    for (int k = 0; k < MASK_N; k++) begin
      mask[k] = online_nxt[k];
    end
    pre_f.mask  = mask;
    main_f.mask = mask;
    pre_f.last  = !main_v;
    main_f.last = 1'b1;

    push.v0 = pre_v || main_v;
    push.v1 = pre_v && main_v;
    push.f0 = pre_v ? pre_f : main_f;
    push.f1 = main_f;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      cur_r   <= '0;
      sadv_r  <= '0;
      sact_r  <= '0;
      bcast_r <= 1'b0;
      known_r <= '0;
      for (int k = 0; k < NUM_SLAVES; k++) begin
        online_r[k] <= 1'b0;
        tc_r[k]     <= '0;
      end
    end else begin
      phase_r  <= phase_nxt;
      cur_r    <= cur_nxt;
      sadv_r   <= sadv_nxt;
      sact_r   <= sact_nxt;
      bcast_r  <= bcast_nxt;
      known_r  <= known_nxt;
      online_r <= online_nxt;
      tc_r     <= tc_nxt;
    end
  end

  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      poll_intv_r <= POLL_INTERVAL_RST;
      rsp_tmo_r   <= RSP_TIMEOUT_RST;
      off_thr_r   <= OFFLINE_THR_RST;
    end else if (cfg_wr) begin
      case (cfg_paddr[3:2])
        REG_POLL_INTERVAL: poll_intv_r <= cfg_pwdata[15:0];
        REG_RSP_TIMEOUT:   rsp_tmo_r   <= cfg_pwdata[15:0];
        REG_OFFLINE_THR:   off_thr_r   <= cfg_pwdata[3:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[3:2])
      REG_POLL_INTERVAL: cfg_prdata = {16'd0, poll_intv_r};
      REG_RSP_TIMEOUT:   cfg_prdata = {16'd0, rsp_tmo_r};
      REG_OFFLINE_THR:   cfg_prdata = {28'd0, off_thr_r};
      default:           cfg_prdata = '0;
    endcase
  end

  rrpm_frame_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (room),
    .out_valid (out_tvalid),
    .out_frame (out_frame),
    .out_ready (out_tready)
  );

  assign out_tuser = out_frame.kind;
  assign out_tlast = out_frame.last;
  assign out_tdata = {5'd0, out_frame.mask, out_frame.state, out_frame.err, out_frame.target};

  `ASSERT_CLK(a_pair_starts_state, push.v1 |-> push.f0.kind == FK_STATE, "frame pair without state frame first")
  `ASSERT_CLK(a_single_last, push.v1 |-> (!push.f0.last && push.f1.last), "last mark misplaced")
  `ASSERT_CLK(a_no_done, phase_r != PH_DONE, "phase reached done")
  `ASSERT_ALWAYS(a_pready_high, cfg_pready, "register port not ready")

endmodule

`default_nettype wire
